>>> sv/qph_pkg.sv
// Shared types, constants and helper functions for the quadratic probe hash map.
package qph_pkg;

    // Table geometry
    localparam int CAPACITY    = 67;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = 7;
    localparam int KEY_BYTES   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] HASH_SEED = 64'd5381;

    // Commands
    localparam logic [1:0] CMD_GET = 2'd0;
    localparam logic [1:0] CMD_SET = 2'd1;
    localparam logic [1:0] CMD_POP = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_MISS     = 2'd0;
    localparam logic [1:0] ST_HIT      = 2'd1;
    localparam logic [1:0] ST_INSERTED = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    // Slot flags
    localparam logic [1:0] FLAG_EMPTY   = 2'd0;
    localparam logic [1:0] FLAG_USED    = 2'd1;
    localparam logic [1:0] FLAG_DELETED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_bytes;
        logic [3:0]  key_len;
        logic [63:0] new_value;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [6:0]  entry_total;
    } t_out;

    // Classified request handed from the front end to the probe engine
    typedef struct packed {
        logic [1:0]        cmd;
        logic [63:0]       key;
        logic [3:0]        key_len;
        logic [63:0]       new_value;
        logic [SLOT_W-1:0] home;
    } t_req;

    // One table slot as stored in the slot memory
    typedef struct packed {
        logic [1:0]  flag;
        logic [63:0] key;
        logic [3:0]  key_len;
        logic [63:0] value;
    } t_slot;

    // Keeps the low len bytes of a key
    function automatic logic [63:0] key_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int k = 0; k < KEY_BYTES; k++) begin
            if (4'(k) < len) begin
                m[k*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

>>> sv/quadratic_probe_hash_map.sv
// Top level of the quadratic probe hash map: front end, request queue and probe engine.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready with an i_in_data payload (get, set
//   or pop, a key of up to eight bytes and a value). Each request produces exactly
//   one result on o_out_valid / i_out_ready carrying status, value and the number
//   of live entries after the request.
//   Flow: the front end hashes the key, reduces the hash to a home slot and
//   queues the request. The probe engine picks it up, does a slot memory read
//   and then a check for each probe, up to 67 probes, and loads the output
//   register with the result.
//   Overlap: the front end and the probe engine overlap through a two-entry
//   queue, so the sustained rate is set by the slower of the hash/modulo unit
//   and the probe loop.
//   Reset (synchronous, active low) empties the table and the queue at once.
//   When the receiver stalls, the result holds in the output register; the engine
//   keeps probing the next request and the front end keeps taking transfers until
//   the queue fills.
module quadratic_probe_hash_map
    import qph_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_req q_in;
    t_req q_out;

    // Hash and home slot
    qph_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (q_push),
        .o_req      (q_in),
        .i_full     (q_full)
    );

    // Request queue
    qph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_req   (q_out),
        .o_empty (q_empty)
    );

    // Probe engine and result register
    qph_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_req       (q_out),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> sv/qph_front.sv
// Front end: takes requests, hashes the key and reduces it to a home slot.
module qph_front
    import qph_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_push,
    output t_req o_req,
    input  logic i_full
);

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_MOD, F_PUSH} t_fstate;

    t_fstate           r_state;
    logic [1:0]        r_cmd;
    logic [63:0]       r_key;
    logic [3:0]        r_len;
    logic [63:0]       r_nv;
    logic [63:0]       r_h;
    logic [3:0]        r_bi;
    logic [3:0]        r_nib;
    logic [SLOT_W-1:0] r_home;

    logic [3:0]        len_sat;
    logic [7:0]        cur_byte;
    logic [63:0]       n_h;
    logic [SLOT_W-1:0] n_home;

    assign len_sat  = (i_in_data.key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : i_in_data.key_len;
    assign cur_byte = r_key[r_bi[2:0]*8 +: 8];
    // h * 33 + signed byte
    assign n_h = (r_h << 5) + r_h + {{56{cur_byte[7]}}, cur_byte};

    // Four bits of the modulo reduction per cycle, most significant first
    always_comb begin
        logic [SLOT_W:0] r;
        r = {1'b0, r_home};
        for (int b = 3; b >= 0; b--) begin
            r = {r[SLOT_W-1:0], r_h[60 + b]};
            if (r >= (SLOT_W+1)'(CAPACITY)) begin
                r = r - (SLOT_W+1)'(CAPACITY);
            end
        end
        n_home = r[SLOT_W-1:0];
    end

    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_req      = '{cmd: r_cmd, key: r_key, key_len: r_len, new_value: r_nv,
                          home: r_home};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_data.cmd;
                        r_len   <= len_sat;
                        r_key   <= i_in_data.key_bytes & key_mask(len_sat);
                        r_nv    <= i_in_data.new_value;
                        r_h     <= HASH_SEED;
                        r_bi    <= '0;
                        r_state <= F_HASH;
                    end
                end
                F_HASH: begin
                    if (r_bi == r_len) begin
                        r_h     <= ~r_h;
                        r_home  <= '0;
                        r_nib   <= '0;
                        r_state <= F_MOD;
                    end else begin
                        r_h  <= n_h;
                        r_bi <= r_bi + 4'd1;
                    end
                end
                F_MOD: begin
                    r_home <= n_home;
                    r_h    <= r_h << 4;
                    r_nib  <= r_nib + 4'd1;
                    if (r_nib == 4'd15) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

>>> sv/qph_fifo.sv
// Short request queue between the front end and the probe engine.
module qph_fifo
    import qph_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output t_req o_req,
    output logic o_empty
);

    t_req              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_req   = r_mem[r_rp];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wp + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rp + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

>>> sv/qph_back.sv
// Probe engine: walks the quadratic probe path in the slot memory and builds results.
module qph_back
    import qph_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_req i_req,
    output logic o_pop,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    typedef enum logic [1:0] {B_IDLE, B_RD, B_CHK, B_OUT} t_bstate;

    t_bstate              r_state;
    t_req                 r_req;
    logic [SLOT_W-1:0]    r_p;
    logic [SLOT_W-1:0]    r_d;
    logic [SLOT_W-1:0]    r_i;
    logic                 r_have_free;
    logic [SLOT_W-1:0]    r_free_slot;
    logic [COUNT_W-1:0]   r_live;
    logic [CAPACITY-1:0]  r_vld;
    t_slot                r_rd;
    t_slot                r_slots [CAPACITY];
    logic [1:0]           r_res_status;
    logic [63:0]          r_res_value;
    t_out                 r_out;
    logic                 r_out_v;

    logic [1:0]        cur_flag;
    logic              is_used;
    logic              match;
    logic              free_any;
    logic [SLOT_W-1:0] free_slot;
    logic              last;
    logic [SLOT_W:0]   p_sum;
    logic [SLOT_W:0]   d_sum;
    logic [SLOT_W-1:0] p_nx;
    logic [SLOT_W-1:0] d_nx;
    logic              hit_pop;
    logic              we;
    logic [SLOT_W-1:0] wa;
    t_slot             wd;

    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Probe classification
    assign cur_flag  = r_vld[r_p] ? r_rd.flag : FLAG_EMPTY;
    assign is_used   = (cur_flag == FLAG_USED);
    assign match     = is_used && (r_rd.key_len == r_req.key_len) && (r_rd.key == r_req.key);
    assign free_any  = r_have_free || !is_used;
    assign free_slot = r_have_free ? r_free_slot : r_p;
    assign last      = (cur_flag == FLAG_EMPTY) || (r_i == SLOT_W'(CAPACITY-1));
    assign hit_pop   = (r_state == B_CHK) && match && (r_req.cmd == CMD_POP);

    // Next probe: p += 2i+1, step grows by 2, both kept below the capacity
    assign p_sum = {1'b0, r_p} + {1'b0, r_d};
    assign d_sum = {1'b0, r_d} + (SLOT_W+1)'(2);
    assign p_nx  = (p_sum >= (SLOT_W+1)'(CAPACITY)) ? SLOT_W'(p_sum - (SLOT_W+1)'(CAPACITY))
                                                    : SLOT_W'(p_sum);
    assign d_nx  = (d_sum >= (SLOT_W+1)'(CAPACITY)) ? SLOT_W'(d_sum - (SLOT_W+1)'(CAPACITY))
                                                    : SLOT_W'(d_sum);

    // Slot write for update, delete and insert
    always_comb begin
        we = 1'b0;
        wa = r_p;
        wd = '{flag: FLAG_USED, key: r_req.key, key_len: r_req.key_len,
               value: r_req.new_value};
        if (r_state == B_CHK) begin
            if (match) begin
                if (r_req.cmd == CMD_SET) begin
                    we = 1'b1;
                end else if (r_req.cmd == CMD_POP) begin
                    we      = 1'b1;
                    wd.flag = FLAG_DELETED;
                end
            end else if (last && (r_req.cmd == CMD_SET) && free_any) begin
                we = 1'b1;
                wa = free_slot;
            end
        end
    end

    // Slot memory with registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_slots[wa] <= wd;
        end
        r_rd <= r_slots[r_p];
    end

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_live  <= '0;
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_req        <= i_req;
                        r_p          <= i_req.home;
                        r_d          <= SLOT_W'(1);
                        r_i          <= '0;
                        r_have_free  <= 1'b0;
                        r_res_status <= ST_MISS;
                        r_res_value  <= '0;
                        if (i_req.cmd == CMD_GET || i_req.cmd == CMD_SET ||
                            i_req.cmd == CMD_POP) begin
                            r_state <= B_RD;
                        end else begin
                            r_state <= B_OUT;
                        end
                    end
                end
                B_RD: begin
                    r_state <= B_CHK;
                end
                B_CHK: begin
                    if (!r_have_free && !is_used) begin
                        r_have_free <= 1'b1;
                        r_free_slot <= r_p;
                    end
                    if (match) begin
                        r_res_status <= ST_HIT;
                        r_res_value  <= r_rd.value;
                        if (r_req.cmd == CMD_POP && r_live != '0) begin
                            r_live <= r_live - COUNT_W'(1);
                        end
                        r_state <= B_OUT;
                    end else if (last) begin
                        if (r_req.cmd == CMD_SET) begin
                            if (free_any) begin
                                r_res_status     <= ST_INSERTED;
                                r_vld[free_slot] <= 1'b1;
                                r_live           <= r_live + COUNT_W'(1);
                            end else begin
                                r_res_status <= ST_FULL;
                            end
                        end
                        r_state <= B_OUT;
                    end else begin
                        r_p     <= p_nx;
                        r_d     <= d_nx;
                        r_i     <= r_i + SLOT_W'(1);
                        r_state <= B_RD;
                    end
                end
                B_OUT: begin
                    if (!r_out_v || i_out_ready) begin
                        r_out   <= '{status: r_res_status, value: r_res_value,
                                     entry_total: r_live};
                        r_out_v <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Live entries never exceed the table size
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= COUNT_W'(CAPACITY))
        else $error("live count above capacity");

    // Probe position and step stay inside the table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RD || r_state == B_CHK) |->
            (r_p < SLOT_W'(CAPACITY)) && (r_d < SLOT_W'(CAPACITY)))
        else $error("probe position out of range");

    // A pop hit removes exactly one live entry
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_pop |=> (r_live == $past(r_live) - COUNT_W'(1)))
        else $error("pop did not decrement live count");

    // A result is loaded only after a request was finished
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_v) && r_out_v) |-> $past(r_state == B_OUT))
        else $error("result loaded outside output state");

endmodule

>>> test/tb.sv
// Testbench for the quadratic probe hash map: directed table, random traffic, predictor check.
`timescale 1ns / 100ps

module tb;
    import qph_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    quadratic_probe_hash_map u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor copy of the table
    logic [1:0]  mdl_flag [CAPACITY];
    logic [63:0] mdl_key  [CAPACITY];
    logic [3:0]  mdl_len  [CAPACITY];
    logic [63:0] mdl_val  [CAPACITY];
    int          mdl_live;

    t_out pending_results[$];
    int   err_cnt = 0;
    int   idle_cycles = 0;
    int   n_sent = 0;
    int   n_hit = 0, n_ins = 0, n_full = 0;
    bit   calm = 1'b0;

    // djb2 over the first len bytes, inverted, reduced to home slot
    function automatic int home_slot(input logic [63:0] key, input logic [3:0] len);
        logic [63:0] h;
        h = HASH_SEED;
        for (int k = 0; k < len; k++) begin
            h = h * 64'd33 + {{56{key[k*8+7]}}, key[k*8 +: 8]};
        end
        h = ~h;
        return int'(h % 64'(CAPACITY));
    endfunction

    function automatic t_out table_update(input t_in req);
        t_out r;
        logic [3:0]  len;
        logic [63:0] key;
        int home, p, found;
        r = '0;
        len = (req.key_len > 4'd8) ? 4'd8 : req.key_len;
        key = '0;
        for (int k = 0; k < 8; k++) begin
            if (k < len) key[k*8 +: 8] = req.key_bytes[k*8 +: 8];
        end
        home = home_slot(key, len);
        found = -1;
        if (req.cmd != 2'd3) begin
            for (int i = 0; i < CAPACITY; i++) begin
                p = (home + i * i) % CAPACITY;
                if (mdl_flag[p] == FLAG_EMPTY) break;
                if (mdl_flag[p] == FLAG_USED && mdl_len[p] == len && mdl_key[p] == key) begin
                    found = p;
                    break;
                end
            end
            if (found >= 0) begin
                r.status = ST_HIT;
                r.value = mdl_val[found];
                if (req.cmd == CMD_SET) mdl_val[found] = req.new_value;
                if (req.cmd == CMD_POP) begin
                    mdl_flag[found] = FLAG_DELETED;
                    mdl_live--;
                end
            end else if (req.cmd == CMD_SET) begin
                r.status = ST_FULL;
                for (int i = 0; i < CAPACITY; i++) begin
                    p = (home + i * i) % CAPACITY;
                    if (mdl_flag[p] != FLAG_USED) begin
                        mdl_flag[p] = FLAG_USED;
                        mdl_key[p] = key;
                        mdl_len[p] = len;
                        mdl_val[p] = req.new_value;
                        mdl_live++;
                        r.status = ST_INSERTED;
                        break;
                    end
                end
            end
        end
        r.entry_total = 7'(mdl_live);
        return r;
    endfunction

    // Send one transfer, with an optional random gap first; valid stays high otherwise
    task automatic send_req(input t_in req);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(table_update(req));
        n_sent++;
    endtask

    // Receiver stall pattern
    initial begin : out_ready_gen
        int burst;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 12);
                i_out_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    // Result check against the oldest expectation
    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, o_out_data);
                err_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.status == ST_HIT) n_hit++;
                if (exp_r.status == ST_INSERTED) n_ins++;
                if (exp_r.status == ST_FULL) n_full++;
                if (o_out_data.status !== exp_r.status) begin
                    $display("%0t status: expected %0d, actual %0d", $time,
                             exp_r.status, o_out_data.status);
                    err_cnt++;
                end
                if (o_out_data.value !== exp_r.value) begin
                    $display("%0t value: expected %h, actual %h", $time,
                             exp_r.value, o_out_data.value);
                    err_cnt++;
                end
                if (o_out_data.entry_total !== exp_r.entry_total) begin
                    $display("%0t entry_total: expected %0d, actual %0d", $time,
                             exp_r.entry_total, o_out_data.entry_total);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_in mk(input logic [1:0] c, input logic [63:0] k,
                               input logic [3:0] l, input logic [63:0] v);
        t_in r;
        r.cmd = c;
        r.key_bytes = k;
        r.key_len = l;
        r.new_value = v;
        return r;
    endfunction

    // Directed rows; fixed expectations where obvious, else predictor
    typedef struct {
        t_in  req;
        bit   has_exp;
        t_out exp_r;
    } t_row;

    t_row dir_rows[$];

    // Random key drawn from a pool of the given size, so hits and deletes recur
    function automatic t_in rand_req(input int pool);
        logic [63:0] k;
        int sel;
        sel = $urandom_range(0, pool - 1);
        k = {32'(sel * 2654435761), 32'(sel)};
        if ($urandom_range(0, 7) == 0) k = {$urandom, $urandom};
        return mk((($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2))),
                  k | ({$urandom, $urandom} & ~key_mask(4'(sel % 9))),
                  ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'(sel % 9),
                  {$urandom, $urandom});
    endfunction

    initial begin
        t_out r;
        for (int i = 0; i < CAPACITY; i++) mdl_flag[i] = FLAG_EMPTY;
        mdl_live = 0;

        dir_rows.push_back('{mk(CMD_GET, 64'h0, 4'd0, 64'h0), 1, '{ST_MISS, 64'h0, 7'd0}});
        dir_rows.push_back('{mk(CMD_POP, '1, 4'd8, '1), 1, '{ST_MISS, 64'h0, 7'd0}});
        dir_rows.push_back('{mk(CMD_SET, '1, 4'd8, '1), 1, '{ST_INSERTED, 64'h0, 7'd1}});
        dir_rows.push_back('{mk(CMD_GET, '1, 4'd8, 64'h0), 1, '{ST_HIT, '1, 7'd1}});
        dir_rows.push_back('{mk(CMD_GET, '1, 4'd15, 64'h0), 1, '{ST_HIT, '1, 7'd1}});
        dir_rows.push_back('{mk(CMD_SET, '1, 4'd8, 64'h0), 1, '{ST_HIT, '1, 7'd1}});
        dir_rows.push_back('{mk(2'd3, '1, 4'd8, '1), 1, '{ST_MISS, 64'h0, 7'd1}});
        dir_rows.push_back('{mk(CMD_SET, 64'h0, 4'd0, 64'h5), 1, '{ST_INSERTED, 64'h0, 7'd2}});
        dir_rows.push_back('{mk(CMD_GET, 64'hDEAD, 4'd0, 64'h0), 1, '{ST_HIT, 64'h5, 7'd2}});
        dir_rows.push_back('{mk(CMD_SET, 64'hFFFF_FF80, 4'd1, 64'h7), 0, '0});
        dir_rows.push_back('{mk(CMD_GET, 64'h80, 4'd1, 64'h0), 0, '0});
        dir_rows.push_back('{mk(CMD_GET, 64'h80, 4'd2, 64'h0), 0, '0});
        dir_rows.push_back('{mk(CMD_POP, '1, 4'd8, 64'h0), 1, '{ST_HIT, 64'h0, 7'd2}});
        dir_rows.push_back('{mk(CMD_GET, '1, 4'd8, 64'h0), 1, '{ST_MISS, 64'h0, 7'd2}});
        dir_rows.push_back('{mk(CMD_SET, 64'h7F, 4'd1, 64'h1), 0, '0});
        dir_rows.push_back('{mk(CMD_SET, 64'h0706050403020100, 4'd7, 64'h2), 0, '0});
        dir_rows.push_back('{mk(CMD_POP, 64'h0706050403020100, 4'd7, 64'h0), 0, '0});
        dir_rows.push_back('{mk(CMD_SET, '1, 4'd8, 64'h3), 0, '0});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every row moves the predictor; typed rows are compared against it
        foreach (dir_rows[i]) begin
            r = table_update(dir_rows[i].req);
            if (dir_rows[i].has_exp && (r != dir_rows[i].exp_r)) begin
                $display("%0t table row %0d: expected %h, predictor %h", $time, i,
                         dir_rows[i].exp_r, r);
                err_cnt++;
            end
        end
        // Rebuild predictor state, then drive the rows for real
        for (int i = 0; i < CAPACITY; i++) mdl_flag[i] = FLAG_EMPTY;
        mdl_live = 0;
        foreach (dir_rows[i]) send_req(dir_rows[i].req);
        i_in_valid <= 1'b0;

        // Hold off until the pipeline drains
        while (pending_results.size() != 0) @(posedge i_clk);

        // Random traffic: 300 requests from a small pool, then 200 from a large pool to fill the table, repeated
        for (int n = 0; n < 1750; n++) begin
            if (n == 1500) calm = 1'b1;
            send_req(rand_req((n % 500 < 300) ? 24 : 120));
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests: %0d hits, %0d inserts, %0d table-full results.",
                 n_sent, n_hit, n_ins, n_full);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
